/* sv/u128_pkg.sv */
package u128_pkg;

    localparam int LIMB_W = 32;
    localparam int NUM_LIMBS = 4;
    localparam int WORD_W = LIMB_W * NUM_LIMBS;
    localparam int ACT_W = 3;
    localparam int STAT_W = 2;
    localparam int ORD_W = 2;
    localparam int DIV_STEPS = WORD_W;

    localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADDS = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MULS = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DIVS = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CMP = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVF = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIV0 = 2'd2;

    localparam logic [ORD_W-1:0] ORD_EQ = 2'd0;
    localparam logic [ORD_W-1:0] ORD_GT = 2'd1;
    localparam logic [ORD_W-1:0] ORD_LT = 2'd3;

    // Item travelling down the cell row.
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic [LIMB_W-1:0] scalar;
        logic [WORD_W-1:0] quot;     // quotient bits / running work word
        logic [LIMB_W:0]   rem;      // partial remainder, one spare bit
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic [STAT_W-1:0] status;
        logic [LIMB_W-1:0] remainder;
        logic [ORD_W-1:0]  order;
    } res_t;

endpackage

/* sv/u128_div_cell.sv */
// One restoring-division step: shifts one dividend bit into the partial
// remainder, then subtracts the divisor if it fits.
module u128_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  u128_pkg::item_t   in_item,
    output logic              out_vld,
    output u128_pkg::item_t   out_item
);

    logic                        vld_reg;
    u128_pkg::item_t             item_reg;
    u128_pkg::item_t             item_next;
    logic [u128_pkg::LIMB_W:0]   shifted;
    logic [u128_pkg::LIMB_W+1:0] diff;

    always_comb
    begin
        item_next = in_item;
        shifted   = {in_item.rem[u128_pkg::LIMB_W-1:0],
                     in_item.quot[u128_pkg::WORD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, in_item.scalar};
        item_next.quot = {in_item.quot[u128_pkg::WORD_W-2:0], 1'b0};
        if (!diff[u128_pkg::LIMB_W+1])
        begin
            item_next.rem     = diff[u128_pkg::LIMB_W:0];
            item_next.quot[0] = 1'b1;
        end
        else
        begin
            item_next.rem = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

/* sv/u128_fin.sv */
// Final stage: computes the non-division operations and selects the result.
module u128_fin (
    input  u128_pkg::item_t item,
    output u128_pkg::res_t  res
);

    logic [u128_pkg::WORD_W:0]   sum;
    logic [u128_pkg::WORD_W:0]   dif;
    logic [u128_pkg::WORD_W:0]   sums;
    logic [u128_pkg::WORD_W+u128_pkg::LIMB_W-1:0] prod;
    logic [u128_pkg::LIMB_W-1:0] acc;
    logic [2*u128_pkg::LIMB_W-1:0] part;
    logic [u128_pkg::WORD_W-1:0] plo;
    integer i;

    always_comb
    begin
        sum  = {1'b0, item.left} + {1'b0, item.right};
        dif  = {1'b0, item.left} - {1'b0, item.right};
        sums = {1'b0, item.left} + {{(u128_pkg::WORD_W-u128_pkg::LIMB_W+1){1'b0}}, item.scalar};
        acc = '0;
        plo = '0;
        for (i = 0; i < u128_pkg::NUM_LIMBS; i++)
        begin
            part = {32'd0, item.left[i*u128_pkg::LIMB_W +: u128_pkg::LIMB_W]}
                   * {32'd0, item.scalar} + {32'd0, acc};
            plo[i*u128_pkg::LIMB_W +: u128_pkg::LIMB_W] = part[u128_pkg::LIMB_W-1:0];
            acc = part[2*u128_pkg::LIMB_W-1:u128_pkg::LIMB_W];
        end
        prod = {acc, plo};

        res.result    = item.left;
        res.status    = u128_pkg::ST_OK;
        res.remainder = '0;
        res.order     = u128_pkg::ORD_EQ;
        unique case (item.action)
            u128_pkg::ACT_ADD:
                if (sum[u128_pkg::WORD_W]) res.status = u128_pkg::ST_OVF;
                else res.result = sum[u128_pkg::WORD_W-1:0];
            u128_pkg::ACT_SUB:
                if (dif[u128_pkg::WORD_W]) res.status = u128_pkg::ST_OVF;
                else res.result = dif[u128_pkg::WORD_W-1:0];
            u128_pkg::ACT_ADDS:
                if (sums[u128_pkg::WORD_W]) res.status = u128_pkg::ST_OVF;
                else res.result = sums[u128_pkg::WORD_W-1:0];
            u128_pkg::ACT_MULS:
                if (acc != '0) res.status = u128_pkg::ST_OVF;
                else res.result = prod[u128_pkg::WORD_W-1:0];
            u128_pkg::ACT_DIVS:
                if (item.scalar == '0) res.status = u128_pkg::ST_DIV0;
                else
                begin
                    res.result    = item.quot;
                    res.remainder = item.rem[u128_pkg::LIMB_W-1:0];
                end
            u128_pkg::ACT_CMP:
            begin
                res.result = '0;
                if (dif[u128_pkg::WORD_W]) res.order = u128_pkg::ORD_LT;
                else if (dif[u128_pkg::WORD_W-1:0] != '0) res.order = u128_pkg::ORD_GT;
            end
            default: ;
        endcase
    end

endmodule

/* sv/uint128_arith_unit.sv */
// uint128_arith_unit: unsigned 128-bit add, subtract, add scalar, multiply
// by scalar, divide by scalar with remainder, and compare.
// Input channel s_axis_*: one transaction per operation, tuser = action,
// tdata = operands. Output channel m_axis_*: one transaction per input,
// in order, tdata = result fields.
// Throughput: one transaction per cycle while the output is not stalled.
// The division runs through a chain of 128 one-bit restoring cells, one
// quotient bit per cell, and every operation rides the same chain so order
// is kept; one more register holds the result.
// A stall on m_axis_tready freezes the whole chain (global enable), so
// s_axis_tready is low only while the output register is full and stalled.
// Reset clears all valid bits; payload registers are not reset.
// Multiply by scalar is done in the final stage as four 32x32 limb products.
module uint128_arith_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_high[63:0], left_low[127:64], right_high[191:128],
    // right_low[255:192], scalar[287:256]
    input  logic [287:0] s_axis_tdata,
    // action[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_high[63:0], result_low[127:64], status[129:128],
    // remainder[161:130], order[163:162], zero pad [167:164]
    output logic [167:0] m_axis_tdata
);

    localparam int N = u128_pkg::DIV_STEPS;

    logic            en;
    logic            vld [0:N];
    u128_pkg::item_t itm [0:N];
    u128_pkg::res_t  res;
    logic            out_vld_reg;
    u128_pkg::res_t  out_reg;

    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        itm[0].action = s_axis_tuser;
        itm[0].left   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        itm[0].right  = {s_axis_tdata[191:128], s_axis_tdata[255:192]};
        itm[0].scalar = s_axis_tdata[287:256];
        itm[0].quot   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        itm[0].rem    = '0;
        vld[0]        = s_axis_tvalid;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            u128_div_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .in_vld  (vld[g]),
                .in_item (itm[g]),
                .out_vld (vld[g+1]),
                .out_item(itm[g+1])
            );
        end
    endgenerate

    u128_fin u_fin (
        .item(itm[N]),
        .res (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'd0, out_reg.order, out_reg.remainder, out_reg.status,
                            out_reg.result[63:0], out_reg.result[127:64]};

    // A stalled result must not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Input is always accepted when the output is empty.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("ready low with empty output");

    // Status is never the unused code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[129:128] != 2'd3)
        else $error("bad status");

endmodule
